[sv/baseband_line_encoder_assert.svh]
// Assertion macros used by the line encoder checker.
`ifndef BASEBAND_LINE_ENCODER_ASSERT_SVH
`define BASEBAND_LINE_ENCODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define BLE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define BLE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/ble_pkg.sv]
// Types and constants of the baseband line encoder.
package ble_pkg;

    localparam int NUM_BITS = 8;

    typedef enum logic [1:0] {
        LC_NRZ   = 2'd0,
        LC_MANCH = 2'd1,
        LC_AMI   = 2'd2,
        LC_BAD   = 2'd3
    } t_line_code;

    localparam logic signed [1:0] SYM_ZERO = 2'sd0;
    localparam logic signed [1:0] SYM_POS  = 2'sd1;
    localparam logic signed [1:0] SYM_NEG  = -2'sd1;

    typedef struct packed {
        logic [NUM_BITS-1:0] data_byte;
        logic                message_start;
    } t_in;

    typedef struct packed {
        logic signed [1:0] line_symbol;
        logic              last_symbol;
        logic              code_error;
    } t_out;

endpackage

[sv/baseband_line_encoder.sv]
// Top level of the baseband line encoder: byte in, one line symbol per beat out.
// A byte is loaded into the bit shifter, then each of its symbols is registered into o_out.
// One symbol per cycle while the output is not stalled; a byte gives 8 symbols (NRZ,
// AMI), 16 (Manchester) or 1 (invalid code), counted by r_cnt; the next byte enters on
// the last symbol. Reset clears the busy and output valid flags, sets line code to NRZ
// and the AMI polarity to positive.
module baseband_line_encoder (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  ble_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output ble_pkg::t_out o_out,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_wdata
);
    import ble_pkg::*;

    localparam int CNT_W = $clog2(2 * NUM_BITS);

    t_line_code          r_line_code, n_line_code;
    logic                r_busy, n_busy;
    logic [NUM_BITS-1:0] r_shift, n_shift;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_ami_pos, n_ami_pos;
    logic                r_out_valid, n_out_valid;
    t_out                r_out, n_out;

    logic bit_now, adv, accept, sym_last, shift_en, toggle;
    t_out sym;

    assign bit_now = r_shift[NUM_BITS-1];
    assign adv     = r_busy && (!r_out_valid || !i_out_stall);

    // symbol for the current bit position
    always_comb begin
        sym      = '{line_symbol: SYM_ZERO, last_symbol: 1'b0, code_error: 1'b0};
        sym_last = 1'b0;
        shift_en = 1'b1;
        toggle   = 1'b0;
        case (r_line_code)
            LC_NRZ: begin
                sym.line_symbol = {1'b0, bit_now};
                sym_last        = (r_cnt == CNT_W'(NUM_BITS - 1));
            end
            LC_MANCH: begin
                sym.line_symbol = {1'b0, bit_now ^ r_cnt[0]};
                sym_last        = (r_cnt == CNT_W'(2 * NUM_BITS - 1));
                shift_en        = r_cnt[0];
            end
            LC_AMI: begin
                sym.line_symbol = bit_now ? (r_ami_pos ? SYM_POS : SYM_NEG) : SYM_ZERO;
                sym_last        = (r_cnt == CNT_W'(NUM_BITS - 1));
                toggle          = bit_now;
            end
            default: begin
                sym.code_error = 1'b1;
                sym_last       = 1'b1;
                shift_en       = 1'b0;
            end
        endcase
        sym.last_symbol = sym_last;
    end

    // take a new byte when idle or while the last symbol moves out
    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = r_busy && !(adv && sym_last);

    always_comb begin
        n_line_code = i_cfg_we ? t_line_code'(i_cfg_wdata) : r_line_code;

        n_busy = r_busy;
        if (accept) begin
            n_busy = 1'b1;
        end else if (adv && sym_last) begin
            n_busy = 1'b0;
        end

        n_shift = r_shift;
        n_cnt   = r_cnt;
        if (accept) begin
            n_shift = i_in.data_byte;
            n_cnt   = '0;
        end else if (adv) begin
            n_cnt = r_cnt + CNT_W'(1);
            if (shift_en) begin
                n_shift = {r_shift[NUM_BITS-2:0], 1'b0};
            end
        end

        // flip on each AMI mark, force positive at message start
        n_ami_pos = r_ami_pos ^ (adv && toggle);
        if (accept && i_in.message_start) begin
            n_ami_pos = 1'b1;
        end

        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (adv) begin
            n_out_valid = 1'b1;
            n_out       = sym;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_code <= LC_NRZ;
            r_busy      <= 1'b0;
            r_ami_pos   <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_line_code <= n_line_code;
            r_busy      <= n_busy;
            r_ami_pos   <= n_ami_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_cnt   <= n_cnt;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

[sv/ble_checker.sv]
// Port checker for the baseband line encoder, bound to the top level.
`include "baseband_line_encoder_assert.svh"
module ble_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input ble_pkg::t_out o_out
);
    import ble_pkg::*;

    `BLE_ASSERT_NXT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out),
        "stalled output beat changed")
    `BLE_ASSERT_IMP(a_err_single, i_clk, i_rst_n,
        o_out_valid && o_out.code_error,
        o_out.last_symbol && (o_out.line_symbol == SYM_ZERO),
        "error beat is not a lone zero symbol")
    `BLE_ASSERT_IMP(a_sym_range, i_clk, i_rst_n,
        o_out_valid,
        o_out.line_symbol != 2'b10,
        "line symbol out of range")
    `BLE_ASSERT_IMP(a_neg_no_err, i_clk, i_rst_n,
        o_out_valid && (o_out.line_symbol == SYM_NEG),
        !o_out.code_error,
        "negative mark flagged as error")

endmodule

bind baseband_line_encoder ble_checker u_ble_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

[verif/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the baseband line encoder: NRZ, Manchester, AMI and invalid codes.
module tb_top;
    import ble_pkg::*;

    localparam int RANDOM_BYTES = 390;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 3000;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_stall;
    t_in        i_in        = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out       o_out;
    logic       i_cfg_we    = 1'b0;
    logic [1:0] i_cfg_wdata = 2'd0;

    // Local copy of the block's register and AMI polarity
    t_line_code cur_code     = LC_NRZ;
    logic       ami_mark_pos = 1'b1;

    t_in  pending_bytes[$];
    t_out expected_syms[$];

    int   mismatches = 0;
    int   syms_checked = 0;
    int   bytes_per_code[4] = '{0, 0, 0, 0};
    int   send_gap = 0;
    bit   send_calm = 1'b0;
    int   recv_wait = 0;
    bit   recv_calm = 1'b0;
    int   hold_left = 0;
    bit   hold_off_req = 1'b0;

    baseband_line_encoder u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at %0t: %s, got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Expand one byte into its line symbols under the current code.
    function automatic void encode_byte(t_in item);
        t_out sym;
        logic bit_v;
        if (item.message_start)
            ami_mark_pos = 1'b1;
        sym.code_error = 1'b0;
        case (cur_code)
            LC_NRZ, LC_AMI: begin
                for (int k = 0; k < NUM_BITS; k++) begin
                    bit_v = item.data_byte[NUM_BITS-1-k];
                    sym.line_symbol = bit_v ? SYM_POS : SYM_ZERO;
                    if (cur_code == LC_AMI && bit_v) begin
                        sym.line_symbol = ami_mark_pos ? SYM_POS : SYM_NEG;
                        ami_mark_pos = !ami_mark_pos;
                    end
                    sym.last_symbol = (k == NUM_BITS - 1);
                    expected_syms.push_back(sym);
                end
            end
            LC_MANCH: begin
                // each bit XOR the half-bit clock 0,1
                for (int k = 0; k < 2 * NUM_BITS; k++) begin
                    bit_v = item.data_byte[NUM_BITS-1-(k/2)] ^ k[0];
                    sym.line_symbol = bit_v ? SYM_POS : SYM_ZERO;
                    sym.last_symbol = (k == 2 * NUM_BITS - 1);
                    expected_syms.push_back(sym);
                end
            end
            default: begin
                sym.line_symbol = SYM_ZERO;
                sym.last_symbol = 1'b1;
                sym.code_error  = 1'b1;
                expected_syms.push_back(sym);
            end
        endcase
    endfunction

    // Byte driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                encode_byte(i_in);
                bytes_per_code[cur_code]++;
                send_gap = send_calm ? 0 : $urandom_range(0, 14);
                if ($urandom_range(0, 31) == 0)
                    send_calm = !send_calm;
            end
            // hold the payload while stalled, otherwise advance
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_bytes.size() != 0) begin
                    i_in       <= pending_bytes.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Symbol monitor and receiver stall
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_syms.size() == 0) begin
                    report_mismatch("symbol with no byte behind it",
                                    int'(o_out.line_symbol), 0);
                end else begin
                    want = expected_syms.pop_front();
                    if (o_out.line_symbol !== want.line_symbol)
                        report_mismatch("line_symbol", int'(o_out.line_symbol),
                                        int'(want.line_symbol));
                    if (o_out.last_symbol !== want.last_symbol)
                        report_mismatch("last_symbol", o_out.last_symbol, want.last_symbol);
                    if (o_out.code_error !== want.code_error)
                        report_mismatch("code_error", o_out.code_error, want.code_error);
                end
                syms_checked++;
                recv_wait = recv_calm ? 0 : $urandom_range(0, 14);
                if ($urandom_range(0, 31) == 0)
                    recv_calm = !recv_calm;
            end
            if (hold_off_req) begin
                hold_left    = HOLD_CYCLES;
                hold_off_req = 1'b0;
            end
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (recv_wait > 0) begin
            recv_wait--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("baseband_line_encoder regression: fail");
        $finish;
    end

    task automatic queue_byte(logic [7:0] data, logic start);
        pending_bytes.push_back('{data_byte: data, message_start: start});
    endtask

    // Drop back to idle: every byte taken and every symbol seen.
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (pending_bytes.size() != 0 || i_in_valid || expected_syms.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_line_code(t_line_code code);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= code;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_code = code;
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        t_line_code code;
        int         count;
        int         sent;
        int         phase;
        int         total;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // NRZ straight out of reset
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h01, 1'b0);
        queue_byte(8'hA5, 1'b1);
        wait_drained();

        write_line_code(LC_MANCH);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h55, 1'b1);
        wait_drained();

        // polarity carries across bytes, restarts on message start
        write_line_code(LC_AMI);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h81, 1'b0);
        queue_byte(8'h01, 1'b1);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h03, 1'b0);
        queue_byte(8'h07, 1'b0);
        wait_drained();

        // invalid code: single error beat; message start still resets polarity
        write_line_code(LC_BAD);
        queue_byte(8'h12, 1'b1);
        queue_byte(8'hFF, 1'b0);
        wait_drained();

        write_line_code(LC_AMI);
        queue_byte(8'h80, 1'b0);
        wait_drained();

        // message start under NRZ also resets AMI polarity
        write_line_code(LC_NRZ);
        queue_byte(8'hC3, 1'b1);
        wait_drained();
        write_line_code(LC_AMI);
        queue_byte(8'h80, 1'b0);
        wait_drained();

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_BYTES) begin
            code  = (phase == 0) ? LC_MANCH : t_line_code'($urandom_range(0, 3));
            count = (code == LC_BAD) ? $urandom_range(3, 10) : $urandom_range(20, 60);
            if (count > RANDOM_BYTES - sent)
                count = RANDOM_BYTES - sent;
            write_line_code(code);
            for (int j = 0; j < count; j++)
                queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            // long receiver hold-off while bytes keep coming, fills the block
            if (phase == 0)
                hold_off_req = 1'b1;
            sent += count;
            phase++;
            wait_drained();
        end

        repeat (20) @(posedge i_clk);
        if (expected_syms.size() != 0)
            report_mismatch("symbols never produced", 0, expected_syms.size());
        total = bytes_per_code[0] + bytes_per_code[1] + bytes_per_code[2] + bytes_per_code[3];
        $display("covered %0d bytes, %0d phases: nrz %0d, manch %0d, ami %0d, bad %0d",
                 total, phase, bytes_per_code[LC_NRZ], bytes_per_code[LC_MANCH],
                 bytes_per_code[LC_AMI], bytes_per_code[LC_BAD]);
        $display("checked %0d line symbols, %0d mismatches", syms_checked, mismatches);
        if (mismatches == 0)
            $display("baseband_line_encoder regression: pass");
        else
            $display("baseband_line_encoder regression: fail");
        $finish;
    end

endmodule
